// ----- rtl/display_page_power_controller_assert.svh -----
// Assertion macros for the display page and power controller
`ifndef DISPLAY_PAGE_POWER_CONTROLLER_ASSERT_SVH
`define DISPLAY_PAGE_POWER_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define DPPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// ante implies cons in the next cycle
`define DPPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DPPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DPPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/dppc_pkg.sv -----
// Types, codes and tables shared by the display page and power controller
`timescale 1ns / 1ps
`default_nettype none
package dppc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_DATA_W    = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int MAX_RES       = 3;
  localparam int RES_CNT_W     = 2;
  localparam int RES_DEPTH     = 4;
  localparam int RES_PTR_W     = 2;
  localparam int RES_FILL_W    = 3;

  // action codes
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_NOTIFY  = 2'd1;
  localparam logic [1:0] ACT_MESSAGE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_CNT   = 3'd4;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [23:0] DISPLAY_ON_RST = 24'd30000;
  localparam logic [23:0] NOTIFY_RST     = 24'd10000;
  localparam logic [15:0] REFRESH_RST    = 16'd1000;
  localparam logic [4:0]  PAGE_CNT_RST   = 5'd3;

  typedef enum logic [1:0] {
    EV_ON     = 2'd0,
    EV_OFF    = 2'd1,
    EV_RENDER = 2'd2,
    EV_TEXT   = 2'd3
  } event_t;

  typedef struct packed {
    logic [15:0] debounce;
    logic [23:0] display_on;
    logic [23:0] notify;
    logic [15:0] refresh;
    logic [4:0]  page_cnt;
  } cfg_t;

  typedef struct packed {
    logic       last_level;
    logic       stable_pressed;
    logic       display_on;
    logic       overlay_on;
    logic       was_on;
    logic [3:0] page;
  } flags_t;

  typedef struct packed {
    event_t     ev;
    logic [3:0] page;
    logic       ovl;
    logic       last;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_list_t;

  // next page, indexed by {current page, page count minus one}
  typedef logic [255:0][3:0] page_lut_t;

  function automatic page_lut_t build_page_next();
    page_lut_t  t;
    logic [4:0] v;
    logic [4:0] d;
    for (int p = 0; p < 16; p++) begin
      for (int m = 0; m < 16; m++) begin
        v = 5'(p + 1);
        d = 5'(m + 1);
        for (int k = 0; k < 16; k++) begin
          if (v >= d) begin
            v = v - d;
          end
        end
        t[p * 16 + m] = v[3:0];
      end
    end
    return t;
  endfunction

  localparam page_lut_t PAGE_NEXT = build_page_next();

endpackage
`default_nettype wire

// ----- rtl/dppc_step.sv -----
// Per-item rule: state update and result list for one accepted beat
`timescale 1ns / 1ps
`default_nettype none
module dppc_step #(
  parameter int TIME_BITS = dppc_pkg::TIME_BITS_DEF
) (
  input  logic [1:0]              action_i,
  input  logic                    button_level_i,
  input  dppc_pkg::cfg_t          cfg_i,
  input  dppc_pkg::flags_t        flags_i,
  input  logic [TIME_BITS-1:0]    now_i,
  input  logic [TIME_BITS-1:0]    lcs_i,
  input  logic [TIME_BITS-1:0]    wake_i,
  input  logic [TIME_BITS-1:0]    ovl_i,
  input  logic [TIME_BITS-1:0]    rfs_i,
  output dppc_pkg::flags_t        flags_o,
  output logic [TIME_BITS-1:0]    now_o,
  output logic [TIME_BITS-1:0]    lcs_o,
  output logic [TIME_BITS-1:0]    wake_o,
  output logic [TIME_BITS-1:0]    ovl_o,
  output logic [TIME_BITS-1:0]    rfs_o,
  output dppc_pkg::res_list_t     res_o,
  output logic [dppc_pkg::RES_CNT_W-1:0] res_cnt_o
);
  import dppc_pkg::*;

  localparam int CMP_W = (TIME_BITS > 24) ? TIME_BITS : 24;

  flags_t                fl;
  logic [TIME_BITS-1:0]  now_n, lcs_n, wake_n, ovl_n, rfs_n;
  logic [TIME_BITS-1:0]  since_lc, since_wk, since_ov, since_rf;
  res_list_t             res;
  logic [RES_CNT_W-1:0]  n;
  logic [3:0]            pm1;

  // clamp page count to 1..16
  assign pm1 = (cfg_i.page_cnt == 5'd0) ? 4'd0 :
               (cfg_i.page_cnt > 5'd16) ? 4'd15 : 4'(cfg_i.page_cnt - 5'd1);

  always_comb begin
    fl       = flags_i;
    now_n    = now_i;
    lcs_n    = lcs_i;
    wake_n   = wake_i;
    ovl_n    = ovl_i;
    rfs_n    = rfs_i;
    res      = '0;
    n        = '0;
    since_lc = '0;
    since_wk = '0;
    since_ov = '0;
    since_rf = '0;
    case (action_i)
      ACT_TICK: begin
        now_n = now_i + TIME_BITS'(1);
        if (button_level_i != fl.last_level) begin
          lcs_n         = now_n;
          fl.last_level = button_level_i;
        end
        since_lc = now_n - lcs_n;
        if ((!button_level_i) != fl.stable_pressed &&
            CMP_W'(since_lc) >= CMP_W'(cfg_i.debounce)) begin
          fl.stable_pressed = !button_level_i;
          if (!button_level_i) begin
            if (fl.overlay_on) begin
              fl.overlay_on = 1'b0;
              fl.page       = '0;
            end else if (!fl.display_on) begin
              fl.page = '0;
            end else begin
              fl.page = PAGE_NEXT[{fl.page, pm1}];
            end
            if (!fl.display_on) begin
              fl.display_on = 1'b1;
              res[n] = '{ev: EV_ON, page: fl.page, ovl: fl.overlay_on, last: 1'b0};
              n = n + 1'b1;
            end
            wake_n = now_n;
            rfs_n  = now_n;
            res[n] = '{ev: EV_RENDER, page: fl.page, ovl: fl.overlay_on, last: 1'b0};
            n = n + 1'b1;
          end
        end
        since_ov = now_n - ovl_n;
        since_wk = now_n - wake_n;
        since_rf = now_n - rfs_n;
        if (fl.overlay_on && CMP_W'(since_ov) >= CMP_W'(cfg_i.notify)) begin
          fl.overlay_on = 1'b0;
          if (fl.was_on) begin
            wake_n = now_n;
            rfs_n  = now_n;
            res[n] = '{ev: EV_RENDER, page: fl.page, ovl: 1'b0, last: 1'b0};
            n = n + 1'b1;
          end else begin
            fl.display_on = 1'b0;
            fl.page       = '0;
            res[n] = '{ev: EV_OFF, page: 4'd0, ovl: 1'b0, last: 1'b0};
            n = n + 1'b1;
          end
        end else if (fl.overlay_on) begin
          // hold while the overlay is up
        end else if (fl.display_on && CMP_W'(since_wk) >= CMP_W'(cfg_i.display_on)) begin
          fl.display_on = 1'b0;
          fl.page       = '0;
          res[n] = '{ev: EV_OFF, page: 4'd0, ovl: 1'b0, last: 1'b0};
          n = n + 1'b1;
        end else if (fl.display_on && CMP_W'(since_rf) >= CMP_W'(cfg_i.refresh)) begin
          rfs_n  = now_n;
          res[n] = '{ev: EV_RENDER, page: fl.page, ovl: 1'b0, last: 1'b0};
          n = n + 1'b1;
        end
      end
      ACT_NOTIFY, ACT_MESSAGE: begin
        if (action_i == ACT_NOTIFY) begin
          if (!fl.overlay_on) begin
            fl.was_on = fl.display_on;
          end
          fl.overlay_on = 1'b1;
          ovl_n         = now_n;
        end
        if (!fl.display_on) begin
          fl.display_on = 1'b1;
          res[n] = '{ev: EV_ON, page: fl.page, ovl: fl.overlay_on, last: 1'b0};
          n = n + 1'b1;
        end
        wake_n = now_n;
        res[n] = '{ev: EV_TEXT, page: fl.page, ovl: fl.overlay_on, last: 1'b0};
        n = n + 1'b1;
      end
      default: begin
        // unused code: drop
      end
    endcase
    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end
  end

  assign flags_o   = fl;
  assign now_o     = now_n;
  assign lcs_o     = lcs_n;
  assign wake_o    = wake_n;
  assign ovl_o     = ovl_n;
  assign rfs_o     = rfs_n;
  assign res_o     = res;
  assign res_cnt_o = n;

endmodule
`default_nettype wire

// ----- rtl/dppc_res_fifo.sv -----
// Result queue: takes up to three results a beat, drains one a cycle while pop_i is high
`timescale 1ns / 1ps
`default_nettype none
`include "display_page_power_controller_assert.svh"
module dppc_res_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [dppc_pkg::RES_CNT_W-1:0] push_cnt_i,
  input  dppc_pkg::res_list_t            push_data_i,
  input  logic                           pop_i,
  output dppc_pkg::res_t                 head_o,
  output logic                           valid_o,
  output logic                           ready_o
);
  import dppc_pkg::*;

  res_t                  mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [RES_PTR_W-1:0]  wr_ptr_nxt, rd_ptr_nxt;
  logic [RES_FILL_W-1:0] count_r, count_nxt;
  logic                  do_pop;

  assign valid_o = (count_r != '0);
  assign do_pop  = pop_i && valid_o;
  // room for a full result list
  assign ready_o = (count_r <= RES_FILL_W'(RES_DEPTH - MAX_RES));
  assign head_o  = mem[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push_cnt_i);
  assign rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(do_pop);
  assign count_nxt  = count_r + RES_FILL_W'(push_cnt_i) - RES_FILL_W'(do_pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CNT_W'(k) < push_cnt_i) begin
        mem[wr_ptr_r + RES_PTR_W'(k)] <= push_data_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `DPPC_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, count_r <= RES_FILL_W'(RES_DEPTH), "result queue overfilled")
  `DPPC_ASSERT_IMP(a_push_room, clk, rst_n, push_cnt_i != '0, ready_o, "results pushed without room")
  `DPPC_ASSERT_IMP(a_empty_ptrs, clk, rst_n, count_r == '0, rd_ptr_r == wr_ptr_r, "empty queue with split pointers")

endmodule
`default_nettype wire

// ----- rtl/display_page_power_controller.sv -----
// Results of an accepted beat are registered in the result queue and shown on out_* from its head.
// Throughput: one input beat a cycle unless stalled; results drain one a cycle while out_stall is low,
// and input stalls while more than one result waits in the four-entry result queue.
// Reset: synchronous, active low; clears counter, stamps, flags and queue, loads register
// defaults (50, 30000, 10000, 1000, 3) and marks the button released.
`timescale 1ns / 1ps
`default_nettype none
`include "display_page_power_controller_assert.svh"
module display_page_power_controller #(
  parameter int TIME_BITS = dppc_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic                            in_button_level,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_event_res,
  output logic [3:0]                      out_page,
  output logic                            out_overlay_active,
  output logic                            out_last,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [dppc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dppc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dppc_pkg::*;

  // configuration registers
  cfg_t                 cfg_r;

  // block state: wrapping tick counter, four time stamps and the control flags
  flags_t               flags_r, flags_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] lcs_r, lcs_nxt;
  logic [TIME_BITS-1:0] wake_r, wake_nxt;
  logic [TIME_BITS-1:0] ovl_r, ovl_nxt;
  logic [TIME_BITS-1:0] rfs_r, rfs_nxt;

  res_list_t            res_list;
  logic [RES_CNT_W-1:0] res_cnt;
  logic [RES_CNT_W-1:0] push_cnt;
  res_t                 head;
  logic                 q_ready;
  logic                 in_take;

  // Stall input whenever the queue cannot absorb a full result list; this depends only on
  // registered fill, never on in_valid.
  assign in_stall = !q_ready;
  assign in_take  = in_valid && !in_stall;
  assign push_cnt = in_take ? res_cnt : '0;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce   <= DEBOUNCE_RST;
      cfg_r.display_on <= DISPLAY_ON_RST;
      cfg_r.notify     <= NOTIFY_RST;
      cfg_r.refresh    <= REFRESH_RST;
      cfg_r.page_cnt   <= PAGE_CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   cfg_r.debounce   <= cfg_data[15:0];
        CFG_DISPLAY_ON: cfg_r.display_on <= cfg_data[23:0];
        CFG_NOTIFY:     cfg_r.notify     <= cfg_data[23:0];
        CFG_REFRESH:    cfg_r.refresh    <= cfg_data[15:0];
        CFG_PAGE_CNT:   cfg_r.page_cnt   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // The whole per-beat rule: debounce, press handling, notify and message beats, expiry, auto-off and refresh.
  dppc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .action_i       (in_action),
    .button_level_i (in_button_level),
    .cfg_i          (cfg_r),
    .flags_i        (flags_r),
    .now_i          (now_r),
    .lcs_i          (lcs_r),
    .wake_i         (wake_r),
    .ovl_i          (ovl_r),
    .rfs_i          (rfs_r),
    .flags_o        (flags_nxt),
    .now_o          (now_nxt),
    .lcs_o          (lcs_nxt),
    .wake_o         (wake_nxt),
    .ovl_o          (ovl_nxt),
    .rfs_o          (rfs_nxt),
    .res_o          (res_list),
    .res_cnt_o      (res_cnt)
  );

  // Advance state on every accepted beat; hold otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '{last_level: 1'b1, stable_pressed: 1'b0, display_on: 1'b0,
                   overlay_on: 1'b0, was_on: 1'b0, page: 4'd0};
      now_r   <= '0;
      lcs_r   <= '0;
      wake_r  <= '0;
      ovl_r   <= '0;
      rfs_r   <= '0;
    end else if (in_take) begin
      flags_r <= flags_nxt;
      now_r   <= now_nxt;
      lcs_r   <= lcs_nxt;
      wake_r  <= wake_nxt;
      ovl_r   <= ovl_nxt;
      rfs_r   <= rfs_nxt;
    end
  end

  // Results of a beat land in the queue together and leave one result at a time.
  dppc_res_fifo u_res_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_cnt_i  (push_cnt),
    .push_data_i (res_list),
    .pop_i       (!out_stall),
    .head_o      (head),
    .valid_o     (out_valid),
    .ready_o     (q_ready)
  );

  assign out_event_res      = head.ev;
  assign out_page           = head.page;
  assign out_overlay_active = head.ovl;
  assign out_last           = head.last;

  `DPPC_ASSERT_IMP(a_ovl_needs_disp, clk, rst_n, flags_r.overlay_on, flags_r.display_on, "overlay active while display dark")
  `DPPC_ASSERT_IMP(a_dark_page_zero, clk, rst_n, !flags_r.display_on, flags_r.page == 4'd0, "dark display off page zero")
  `DPPC_ASSERT_IMP(a_off_cleared, clk, rst_n, out_valid && head.ev == EV_OFF, head.page == 4'd0 && !head.ovl, "power-off beat not cleared")

endmodule
`default_nettype wire
